// File: hw/rtl/dtzc_pkg.sv
`default_nettype none

package dtzc_pkg;

  // default frame limits handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // payload widths used by the top level and the line store
  localparam int LINE_W     = 2;   // {lower row bit, upper row bit}
  localparam int COLOUR_W   = 24;  // {red, green, blue}
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;

  // register reset values before clamping to the frame limits
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam int MIN_DIM          = 3;

  localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_THRESHOLD_LEVEL = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: hw/rtl/dtzc_store.sv
`default_nettype none

module dtzc_store
  import dtzc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  output logic                               busy,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]   line_raddr,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] col_raddr,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]   line_waddr,
  input  wire logic [LINE_W-1:0]              line_wdata,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] col_waddr,
  input  wire logic [COLOUR_W-1:0]            col_wdata,
  output logic [LINE_W-1:0]                   line_rdata,
  output logic [COLOUR_W-1:0]                 col_rdata
);

  localparam int LW  = $clog2(MAX_WIDTH);

  logic [LINE_W-1:0]   line_mem [MAX_WIDTH];
  logic [COLOUR_W-1:0] col_mem  [MAX_WIDTH + 1];

  logic [LINE_W-1:0]   line_q;
  logic [COLOUR_W-1:0] col_q;
  logic                line_hit;
  logic                col_hit;
  logic [LINE_W-1:0]   line_fwd;
  logic [COLOUR_W-1:0] col_fwd;
  logic [LW-1:0]       clr_addr;

  // clearing pass over the threshold rows after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == LW'(MAX_WIDTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      line_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      line_mem[line_waddr] <= line_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_mem[col_waddr] <= col_wdata;
    end
  end

  // registered reads, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      line_q <= line_mem[line_raddr];
      col_q  <= col_mem[col_raddr];
    end
  end

  // forward a write that lands in the same cycle as the read of that entry
  always_ff @(posedge clk) begin
    if (rst) begin
      line_hit <= 1'b0;
      col_hit  <= 1'b0;
    end else if (rd_en) begin
      line_hit <= wr_en && (line_waddr == line_raddr);
      col_hit  <= wr_en && (col_waddr == col_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      line_fwd <= line_wdata;
      col_fwd  <= col_wdata;
    end
  end

  assign line_rdata = line_hit ? line_fwd : line_q;
  assign col_rdata  = col_hit ? col_fwd : col_q;

endmodule

`default_nettype wire

// File: hw/rtl/dog_threshold_zero_cross_overlay.sv
`default_nettype none

// Difference-of-Gaussians zero-crossing edge overlay on a raster pixel stream.
// Each input transfer brings two pre-blurred gray values and the original colour;
// the block thresholds wide minus narrow (clamped at zero) against threshold_level
// and marks an interior pixel as edge (255) when any of its eight neighbours has a
// different threshold bit, painting it white in the colour overlay. Border pixels
// carry their own threshold value and keep their colour. Results lag the input by
// one line plus one pixel; after the last pixel of a frame, send one line plus one
// pixel of flush transfers (tuser = 1) to drain the tail, the final result carrying
// tlast. A flush sent before the frame's pixels are all in is taken and dropped.
// Throughput is one transfer per clock unless the output stalls: two line rows and
// a colour delay line live in block memories with registered reads feeding a
// read-modify-write stage, with write forwarding when a frame restart revisits the
// same entry; that stage loads each result into the output register. After reset a
// clearing pass zeroes the threshold rows, during which s_tready stays low;
// configuration writes are taken at any time but belong between frames.
// frame_width and frame_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.

module dog_threshold_zero_cross_overlay
  import dtzc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [39:0]           s_tdata,  // blur_wide, blur_narrow, blue_in, green_in, red_in
  input  wire logic                  s_tuser,  // cmd: 0 pixel, 1 flush
  // result output
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [31:0]                m_tdata,  // edge_value, blue_out, green_out, red_out
  output logic                       m_tlast   // frame_end
);

  localparam int LW  = $clog2(MAX_WIDTH);        // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);    // width value, colour pointer
  localparam int HW  = $clog2(MAX_HEIGHT + 1);   // height value
  localparam int RW  = $clog2(MAX_HEIGHT + 2);   // row counter runs one past height
  localparam int CWX = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CHX = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
  localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  // configuration, held already clamped
  logic [WW-1:0]    w_reg;
  logic [HW-1:0]    h_reg;
  logic [PIX_W-1:0] thr_reg;
  logic [CWX-1:0]   w_wide;
  logic [CHX-1:0]   h_wide;
  logic [WW-1:0]    w_clamped;
  logic [HW-1:0]    h_clamped;

  // raster counters of the input side
  logic [LW-1:0] col;
  logic [RW-1:0] row;
  logic [WW-1:0] cptr;  // colour delay line slot, wraps after frame width + 1

  // read stage towards the memories
  logic                s1_valid;
  logic                s1_t;
  logic [COLOUR_W-1:0] s1_colour;
  logic [LW-1:0]       s1_col;
  logic [WW-1:0]       s1_cptr;
  logic                s1_out;
  logic                s1_border;
  logic                s1_last;
  logic                s1_adv;
  logic                s1_fire;

  logic [8:0] window_bits;
  logic [8:0] window_next;

  // output register
  logic [PIX_W-1:0]    m_edge;
  logic [COLOUR_W-1:0] m_colour;

  // store interface
  logic                clr_busy;
  logic                rd_en;
  logic [LINE_W-1:0]   line_rdata;
  logic [COLOUR_W-1:0] col_rdata;
  logic [LINE_W-1:0]   line_wdata;

  // input side decode
  logic            in_xfer;
  logic            flush;
  logic            complete;
  logic            restart;
  logic            proceed;
  logic [RW-1:0]   r_e;
  logic [LW-1:0]   c_e;
  logic [WW-1:0]   p_e;
  logic [WW-1:0]   c_w;
  logic [WW-1:0]   ec;
  logic [RW-1:0]   er;
  logic [RW-1:0]   h_ext;
  logic            pos_ge;
  logic            out_en;
  logic            border;
  logic            last;
  logic [PIX_W-1:0] blur_wide;
  logic [PIX_W-1:0] blur_narrow;
  logic [PIX_W-1:0] diff;
  logic            t_bit;
  logic [COLOUR_W-1:0] in_colour;

  // stage one results
  logic                old_a;
  logic                old_b;
  logic                s1_edge_on;
  logic [PIX_W-1:0]    s1_edge;
  logic [COLOUR_W-1:0] s1_colour_out;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    w_wide = CWX'(cfg_data);
    h_wide = CHX'(cfg_data);
    if (w_wide < CWX'(MIN_DIM)) begin
      w_clamped = WW'(MIN_DIM);
    end else if (w_wide > CWX'(MAX_WIDTH)) begin
      w_clamped = WW'(MAX_WIDTH);
    end else begin
      w_clamped = WW'(w_wide);
    end
    if (h_wide < CHX'(MIN_DIM)) begin
      h_clamped = HW'(MIN_DIM);
    end else if (h_wide > CHX'(MAX_HEIGHT)) begin
      h_clamped = HW'(MAX_HEIGHT);
    end else begin
      h_clamped = HW'(h_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg   <= WW'(W_RST);
      h_reg   <= HW'(H_RST);
      thr_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     w_reg   <= w_clamped;
        REG_FRAME_HEIGHT:    h_reg   <= h_clamped;
        REG_THRESHOLD_LEVEL: thr_reg <= cfg_data[PIX_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input transfer: position bookkeeping and threshold
  // ---------------------------------------------------------------------------
  assign s1_adv   = !s1_out || !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && s1_adv;
  assign s_tready = !clr_busy && (!s1_valid || s1_adv);
  assign in_xfer  = s_tvalid && s_tready;

  assign flush    = s_tuser;
  assign h_ext    = RW'(h_reg);
  // all pixels of the frame are in once the row counter reaches the height
  assign complete = (row >= h_ext);
  // a pixel arriving before the tail is drained starts a fresh frame
  assign restart  = complete && !flush;
  // a flush ahead of frame completion is taken and dropped
  assign proceed  = !(flush && !complete);

  assign r_e = restart ? '0 : row;
  assign c_e = restart ? '0 : col;
  assign p_e = restart ? '0 : cptr;
  assign c_w = WW'(c_e);

  // result position trails the input by one line plus one pixel
  assign pos_ge = (r_e >= RW'(2)) || ((r_e == RW'(1)) && (c_e != '0));
  assign ec     = (c_e == '0) ? (w_reg - 1'b1) : (c_w - 1'b1);
  assign er     = (c_e == '0) ? (r_e - RW'(2)) : (r_e - RW'(1));
  assign out_en = pos_ge && (er < h_ext);
  assign border = (er == '0) || (er == h_ext - 1'b1) || (ec == '0) || (ec == w_reg - 1'b1);
  assign last   = (er == h_ext - 1'b1) && (ec == w_reg - 1'b1);

  assign blur_wide   = s_tdata[7:0];
  assign blur_narrow = s_tdata[15:8];
  assign diff        = (blur_wide > blur_narrow) ? (blur_wide - blur_narrow) : PIX_OFF;
  assign t_bit       = !flush && (diff > thr_reg);
  assign in_colour   = flush ? '0 : s_tdata[39:16];

  assign rd_en = in_xfer && proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      cptr <= '0;
    end else if (rd_en) begin
      if (out_en && last) begin
        // frame drained, counters start over
        col  <= '0;
        row  <= '0;
        cptr <= '0;
      end else begin
        if (c_w + 1'b1 >= w_reg) begin
          col <= '0;
          row <= r_e + 1'b1;
        end else begin
          col <= c_e + 1'b1;
          row <= r_e;
        end
        cptr <= (p_e == w_reg) ? '0 : (p_e + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_t      <= t_bit;
      s1_colour <= in_colour;
      s1_col    <= c_e;
      s1_cptr   <= p_e;
      s1_out    <= out_en;
      s1_border <= border;
      s1_last   <= last;
    end
  end

  // ---------------------------------------------------------------------------
  // line rows and colour delay line
  // ---------------------------------------------------------------------------
  dtzc_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .busy       (clr_busy),
    .rd_en      (rd_en),
    .line_raddr (c_e),
    .col_raddr  (p_e),
    .wr_en      (s1_fire),
    .line_waddr (s1_col),
    .line_wdata (line_wdata),
    .col_waddr  (s1_cptr),
    .col_wdata  (s1_colour),
    .line_rdata (line_rdata),
    .col_rdata  (col_rdata)
  );

  // ---------------------------------------------------------------------------
  // window update, zero-crossing test and overlay
  // ---------------------------------------------------------------------------
  assign old_a      = line_rdata[0];
  assign old_b      = line_rdata[1];
  // rows shift up: upper takes the lower row, lower takes the new bit
  assign line_wdata = {s1_t, old_b};
  assign window_next = {s1_t, old_b, old_a, window_bits[8:3]};

  always_comb begin
    if (s1_border) begin
      s1_edge_on = window_next[4];
    end else begin
      s1_edge_on = (window_next != '0) && (window_next != '1);
    end
    s1_edge       = s1_edge_on ? PIX_ON : PIX_OFF;
    s1_colour_out = (s1_edge_on && !s1_border) ? '1 : col_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (s1_fire) begin
      window_bits <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_out) begin
      m_edge   <= s1_edge;
      m_colour <= s1_colour_out;
      m_tlast  <= s1_last;
    end
  end

  assign m_tdata = {m_colour, m_edge};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // no pixel is taken while the line rows are being cleared
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready)
    else $error("input transfer possible during clearing pass");

  // an early flush leaves the read stage untouched
  a_early_flush_dropped: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && flush && !complete && !s1_valid) |=> !s1_valid)
    else $error("early flush entered the pipeline");

  // a stalled read stage keeps its item and address
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_col) && $stable(s1_cptr)))
    else $error("read stage lost its item under back-pressure");

  // the edge map only ever carries the two pixel levels
  a_edge_levels: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[7:0] == PIX_ON) || (m_tdata[7:0] == PIX_OFF)))
    else $error("edge value outside the two levels");

endmodule

`default_nettype wire
